// ----- design/cpt_pkg.sv -----
// Package for the capture pair tachometer.
// Holds widths, constants and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package cpt_pkg;

	localparam int RING_DEPTH = 10;
	localparam int TIMER_BITS = 16;
	localparam int CAPTURE_W = 16;
	localparam int CLOCK_W = 27;
	localparam int FREQ_W = 28;
	localparam int SUM_W = FREQ_W + $clog2(RING_DEPTH);
	localparam int DIV_W = CLOCK_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(1000000);

	// The ring mean is the sum times this rounded-up reciprocal, shifted down by MEAN_SHIFT.
	localparam int MEAN_SHIFT = SUM_W + $clog2(RING_DEPTH) - 1;
	localparam logic [SUM_W-1:0] MEAN_RECIP =
		SUM_W'(((64'd1 << MEAN_SHIFT) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH));

	typedef struct packed {
		logic capture_first;
		logic capture_second;
		logic update;
		logic load_out;
	} cpt_cmd_t;

	typedef struct packed {
		logic pending;
		logic period_zero;
		logic div_done;
		logic out_free;
	} cpt_sts_t;

endpackage

`default_nettype wire

// ----- design/cpt_if.sv -----
// Valid/ready channel interfaces for capture beats and result beats.
// Depends on cpt_pkg.
`default_nettype none

interface cpt_in_if import cpt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CAPTURE_W-1:0] capture_time;

	modport source(output valid, output capture_time, input ready);
	modport sink(input valid, input capture_time, output ready);
endinterface

interface cpt_out_if import cpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency_hz;
	logic [FREQ_W-1:0] mean_frequency_hz;
	logic              period_error;

	modport source(output valid, output frequency_hz, output mean_frequency_hz,
		output period_error, input ready);
	modport sink(input valid, input frequency_hz, input mean_frequency_hz,
		input period_error, output ready);
endinterface

`default_nettype wire

// ----- design/cpt_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on cpt_pkg.
`default_nettype none

module cpt_div import cpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIV_W-1:0]      dividend,
	input  wire logic [TIMER_BITS-1:0] divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           quotient
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [TIMER_BITS-1:0] rem_q;
	logic [TIMER_BITS-1:0] divisor_q;
	logic [DIV_W-1:0]      quo_q;
	logic [TIMER_BITS:0]   shifted;
	logic [TIMER_BITS:0]   diff;
	logic                  fits;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff = shifted - {1'b0, divisor_q};
		fits = (shifted >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIMER_BITS-1:0] : shifted[TIMER_BITS-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = busy_q && (cnt_q == DIV_CNT_W'(1));
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- design/cpt_dp.sv -----
// Datapath: capture pairing, period, history ring, running sum and result register.
// Depends on cpt_pkg, cpt_div.
`default_nettype none

module cpt_dp import cpt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CLOCK_W-1:0]   cfg_wdata,
	input  wire logic [CAPTURE_W-1:0] capture_time,
	input  wire logic                 out_ready,
	input  wire cpt_cmd_t             cmd,
	output cpt_sts_t                  sts,
	output logic                      out_valid,
	output logic [FREQ_W-1:0]         out_freq,
	output logic [FREQ_W-1:0]         out_mean,
	output logic                      out_err
);

	logic [CLOCK_W-1:0]    bus_clock_q;
	logic                  pending_q;
	logic [TIMER_BITS-1:0] first_q;
	logic [FREQ_W-1:0]     ring_q [RING_DEPTH];
	logic [POS_W-1:0]      pos_q;
	logic [SUM_W-1:0]      sum_q;
	logic [FREQ_W-1:0]     freq_q;
	logic                  err_q;
	logic                  out_valid_q;
	logic [FREQ_W-1:0]     out_freq_q;
	logic [FREQ_W-1:0]     out_mean_q;
	logic                  out_err_q;

	logic [TIMER_BITS-1:0] period;
	logic                  div_start;
	logic [DIV_W-1:0]      div_dividend;
	logic                  div_done;
	logic [DIV_W-1:0]      div_quotient;
	logic [FREQ_W-1:0]     new_freq;
	logic [2*SUM_W-1:0]    mean_product;
	logic [FREQ_W-1:0]     ring_mean;

	assign period = capture_time[TIMER_BITS-1:0] - first_q;
	assign new_freq = div_quotient[FREQ_W-1:0];
	assign div_start = cmd.capture_second && (period != '0);
	assign div_dividend = {bus_clock_q, 1'b0};
	assign mean_product = (2*SUM_W)'(sum_q) * (2*SUM_W)'(MEAN_RECIP);
	assign ring_mean = mean_product[MEAN_SHIFT +: FREQ_W];

	cpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (period),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clock_q <= CLOCK_RESET;
			pending_q <= 1'b0;
			first_q <= '0;
			pos_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				bus_clock_q <= cfg_wdata;
			end
			if (cmd.capture_first) begin
				pending_q <= 1'b1;
				first_q <= capture_time[TIMER_BITS-1:0];
			end
			if (cmd.capture_second) begin
				pending_q <= 1'b0;
			end
			if (cmd.update) begin
				sum_q <= sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(new_freq);
				ring_q[pos_q] <= new_freq;
				if (pos_q == POS_W'(RING_DEPTH - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_second) begin
			err_q <= (period == '0);
			freq_q <= '0;
		end
		if (cmd.update) begin
			freq_q <= new_freq;
		end
		if (cmd.load_out) begin
			out_freq_q <= freq_q;
			out_mean_q <= ring_mean;
			out_err_q <= err_q;
		end
	end

	always_comb begin
		sts.pending = pending_q;
		sts.period_zero = (period == '0);
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_freq = out_freq_q;
	assign out_mean = out_mean_q;
	assign out_err = out_err_q;

endmodule

`default_nettype wire

// ----- design/cpt_ctrl.sv -----
// Controller state machine sequencing capture pairing, the frequency division and output.
// Depends on cpt_pkg.
`default_nettype none

module cpt_ctrl import cpt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire cpt_sts_t sts,
	output cpt_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_F,
		S_UPD,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && sts.pending) begin
						state_q <= sts.period_zero ? S_OUT : S_DIV_F;
					end
				end
				S_DIV_F: begin
					if (sts.div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_OUT;
				S_OUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.capture_first = (state_q == S_IDLE) && in_valid && !sts.pending;
		cmd.capture_second = (state_q == S_IDLE) && in_valid && sts.pending;
		cmd.update = (state_q == S_UPD);
		cmd.load_out = (state_q == S_OUT) && sts.out_free;
	end

endmodule

`default_nettype wire

// ----- design/capture_pair_tachometer.sv -----
// Capture pair tachometer top level: pairs capture beats and reports frequency and ring mean.
// A second capture shows its result beat after a restoring division, a ring update state and an
// output load state, or straight from the output load state when both captures are equal;
// a held result beat stalls new captures.
// Reset clears the ring, running sum, pairing state and sets the bus clock to 1000000.
// Depends on cpt_pkg, cpt_if, cpt_ctrl, cpt_dp.
`default_nettype none

module capture_pair_tachometer import cpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CLOCK_W-1:0] cfg_wdata,
	cpt_in_if.sink                  capture,
	cpt_out_if.source               result
);

	cpt_cmd_t cmd;
	cpt_sts_t sts;

	cpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (capture.valid),
		.in_ready (capture.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.capture_time (capture.capture_time),
		.out_ready    (result.ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (result.valid),
		.out_freq     (result.frequency_hz),
		.out_mean     (result.mean_frequency_hz),
		.out_err      (result.period_error)
	);

endmodule

`default_nettype wire
